// File: rtl/kbt_pkg.sv
package kbt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W  = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        kind_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam kind_t KIND_QUERY  = 2'd0;
    localparam kind_t KIND_CREDIT = 2'd1;
    localparam kind_t KIND_DEBIT  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INSUFFICIENT = 2'd1,
        ST_FULL         = 2'd2,
        ST_OVERFLOW     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EXEC = 2'd2,
        S_RESP = 2'd3
    } state_t;

    typedef struct packed {
        word_t key;
        word_t bal;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/kbt_req_if.sv
interface kbt_req_if;
    logic            valid;
    logic            ready;
    kbt_pkg::kind_t  kind;
    kbt_pkg::word_t  asset_id;
    kbt_pkg::word_t  amount;

    modport source (output valid, output kind, output asset_id, output amount, input ready);
    modport sink   (input valid, input kind, input asset_id, input amount, output ready);
endinterface

// File: rtl/kbt_rsp_if.sv
interface kbt_rsp_if;
    logic            valid;
    logic            ready;
    kbt_pkg::word_t  balance;
    logic [1:0]      status;

    modport source (output valid, output balance, output status, input ready);
    modport sink   (input valid, input balance, input status, output ready);
endinterface

// File: rtl/keyed_balance_table_unit.sv
// The result reaches rsp sooner when its key is found early in the scan (one stored key
//   compared per cycle); a key that is not found is compared against every entry.
// A new item is accepted only while idle, after the previous result has been taken.
// The key scan uses the single RAM read port, and one shared 65-bit add/subtract unit
//   serves every credit and debit.
// Reset (rst_n low, asynchronous): sequencer idle, all entries free. The key/balance
//   RAM is not cleared; an entry's contents are used only after it has been written.
module keyed_balance_table_unit
    import kbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    kbt_req_if.sink      req,
    kbt_rsp_if.source    rsp
);

    localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer and scan control
    state_t              state_reg, state_next;
    idx_t                issue_idx_reg, issue_idx_next;
    logic                issue_act_reg, issue_act_next;
    idx_t                cmp_idx_reg, cmp_idx_next;
    logic                cmp_pend_reg, cmp_pend_next;
    logic                hit_reg, hit_next;
    logic                free_found_reg, free_found_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;

    // Item payload and scan results
    kind_t               kind_reg, kind_next;
    word_t               key_reg, key_next;
    word_t               amt_reg, amt_next;
    word_t               cur_reg, cur_next;
    idx_t                hit_idx_reg, hit_idx_next;
    idx_t                free_idx_reg, free_idx_next;

    // Result register
    word_t               bal_reg, bal_next;
    status_t             status_reg, status_next;

    // RAM port
    logic                ram_we;
    idx_t                ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    // Shared add/subtract unit
    logic                alu_sub;
    logic [WORD_W:0]     alu_sum;
    logic                amt_nz;

    assign rd_entry = entry_t'(ram_rdata);
    assign amt_nz   = (amt_reg != '0);

    // Debit subtracts, everything else adds. Bit WORD_W is the carry on a
    // credit and the borrow (amount above balance) on a debit.
    assign alu_sub = (kind_reg == KIND_DEBIT);
    assign alu_sum = alu_sub ? ({1'b0, cur_reg} - {1'b0, amt_reg})
                             : ({1'b0, cur_reg} + {1'b0, amt_reg});

    kbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = (state_reg == S_RESP);
    assign rsp.balance = bal_reg;
    assign rsp.status  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_act_reg  <= 1'b0;
            cmp_pend_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_act_reg  <= issue_act_next;
            cmp_pend_reg   <= cmp_pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        amt_reg       <= amt_next;
        cur_reg       <= cur_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        bal_reg       <= bal_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_idx_next  = issue_idx_reg;
        issue_act_next  = issue_act_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        amt_next        = amt_reg;
        cur_next        = cur_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        bal_next        = bal_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = '{key: key_reg, bal: alu_sum[WORD_W-1:0]};
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Capture the item and start the scan at entry zero.
                if (req.valid)
                begin
                    kind_next       = req.kind;
                    key_next        = req.asset_id;
                    amt_next        = req.amount;
                    cur_next        = '0;
                    issue_idx_next  = '0;
                    issue_act_next  = 1'b1;
                    cmp_pend_next   = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read stage: issue one RAM read per cycle.
                ram_re        = issue_act_reg;
                cmp_pend_next = issue_act_reg;
                cmp_idx_next  = issue_idx_reg;
                if (issue_act_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_act_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end

                // Compare stage: check the entry read last cycle; track the lowest free one.
                if (cmp_pend_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && (rd_entry.key == key_reg))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        cur_next     = rd_entry.bal;
                        state_next   = S_EXEC;
                    end
                    else
                    begin
                        if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_next = S_EXEC;
                        end
                    end
                end
            end

            S_EXEC:
            begin
                bal_next    = cur_reg;
                status_next = ST_OK;
                if ((kind_reg == KIND_CREDIT) && amt_nz)
                begin
                    if (hit_reg)
                    begin
                        if (alu_sum[WORD_W])
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            bal_next = alu_sum[WORD_W-1:0];
                        end
                    end
                    else if (free_found_reg)
                    begin
                        // Take the lowest free entry; with no prior balance the sum is the amount.
                        ram_we                   = 1'b1;
                        ram_waddr                = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        bal_next                 = alu_sum[WORD_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else if ((kind_reg == KIND_DEBIT) && amt_nz)
                begin
                    if (!hit_reg || alu_sum[WORD_W])
                    begin
                        status_next = ST_INSUFFICIENT;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        bal_next = alu_sum[WORD_W-1:0];
                        // Free the entry once it is drained.
                        if (alu_sum[WORD_W-1:0] == '0)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Hold the result until the sink takes it.
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_valid_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(valid_reg))
        else $error("entry valid bits changed outside the update step");

    a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && hit_reg) |-> valid_reg[hit_idx_reg])
        else $error("matched entry is not valid");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && hit_reg) |-> (cur_reg != '0))
        else $error("valid entry holds a zero balance");

    a_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !hit_reg && free_found_reg) |-> !valid_reg[free_idx_reg])
        else $error("chosen free entry is already taken");

    a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_RESP))
        else $error("update step not followed by result");
`endif

endmodule

// File: rtl/kbt_ram.sv
module kbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: verif/tb_keyed_balance_table_unit.sv
module tb_keyed_balance_table_unit;
    import kbt_pkg::*;

    // Kind 3 has no name in the package; the block treats it as a query.
    localparam kind_t KIND_SPARE   = 2'd3;
    localparam word_t ALL_ONES     = '1;
    localparam int    STALL_LIMIT  = 4000;
    localparam int    RANDOM_ITEMS = 620;
    localparam int    REPORT_CAP   = 50;

    // Directed keys: the two extremes, one ordinary key and two more for table pressure.
    localparam word_t KEY_LOW  = 64'h0;
    localparam word_t KEY_A    = 64'h0123_4567_89AB_CDEF;
    localparam word_t KEY_C    = 64'h8000_0000_0000_0001;
    localparam word_t KEY_FILL = 64'hA5A5_5A5A_0000_0010;

    typedef struct packed {
        word_t   balance;
        status_t status;
    } outcome_t;

    // One row of the directed walk. Rows with known = 0 are checked by the predictor;
    // reps > 1 repeats the row with the key stepped by one each time.
    typedef struct {
        kind_t       op;
        word_t       id;
        word_t       amt;
        int unsigned reps;
        bit          known;
        word_t       bal;
        status_t     st;
    } drill_row_t;

    drill_row_t drill_rows [18] = '{
        // empty table: every asset reads zero
        '{KIND_QUERY,  KEY_LOW,  64'd0,     1, 1'b1, 64'd0,     ST_OK},
        // debit of an absent asset is refused
        '{KIND_DEBIT,  KEY_A,    64'd5,     1, 1'b1, 64'd0,     ST_INSUFFICIENT},
        // zero amounts change nothing, absent asset stays absent
        '{KIND_DEBIT,  KEY_A,    64'd0,     1, 1'b1, 64'd0,     ST_OK},
        '{KIND_CREDIT, KEY_A,    64'd0,     1, 1'b1, 64'd0,     ST_OK},
        '{KIND_CREDIT, KEY_A,    64'd100,   1, 1'b1, 64'd100,   ST_OK},
        // unused kind reads like a query, amount ignored
        '{KIND_SPARE,  KEY_A,    64'd7,     1, 1'b1, 64'd100,   ST_OK},
        // debit larger than the balance is refused
        '{KIND_DEBIT,  KEY_A,    64'd101,   1, 1'b1, 64'd100,   ST_INSUFFICIENT},
        // largest key, largest amount, then a wrap that must be refused
        '{KIND_CREDIT, ALL_ONES, ALL_ONES,  1, 1'b1, ALL_ONES,  ST_OK},
        '{KIND_CREDIT, ALL_ONES, 64'd1,     1, 1'b1, ALL_ONES,  ST_OVERFLOW},
        // sum landing exactly on the top is no overflow
        '{KIND_CREDIT, KEY_LOW,  ALL_ONES - 64'd99, 1, 1'b1, ALL_ONES - 64'd99, ST_OK},
        '{KIND_CREDIT, KEY_LOW,  64'd99,    1, 1'b1, ALL_ONES,  ST_OK},
        // fill the remaining thirteen entries
        '{KIND_CREDIT, KEY_FILL, 64'd3,     13, 1'b0, 64'd0,    ST_OK},
        // table full: a new asset is refused
        '{KIND_CREDIT, KEY_C,    64'd5,     1, 1'b1, 64'd0,     ST_FULL},
        // drain one asset to zero, which frees its entry for the new one
        '{KIND_DEBIT,  ALL_ONES, ALL_ONES,  1, 1'b1, 64'd0,     ST_OK},
        '{KIND_CREDIT, KEY_C,    64'd5,     1, 1'b1, 64'd5,     ST_OK},
        '{KIND_DEBIT,  KEY_LOW,  64'd0,     1, 1'b1, ALL_ONES,  ST_OK},
        '{KIND_DEBIT,  KEY_A,    64'd100,   1, 1'b1, 64'd0,     ST_OK},
        '{KIND_QUERY,  KEY_A,    ALL_ONES,  1, 1'b1, 64'd0,     ST_OK}
    };

    logic clk = 1'b0;
    logic rst_n;

    kbt_req_if req_if ();
    kbt_rsp_if rsp_if ();

    keyed_balance_table_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the balance table, kept by the sender at each accepted item.
    bit    ledger_used [ENTRIES];
    word_t ledger_key  [ENTRIES];
    word_t ledger_bal  [ENTRIES];

    outcome_t    pending_results [$];
    outcome_t    oldest_result;
    word_t       key_pool [24];
    int unsigned key_span = 12;
    bit          steady = 1'b0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned status_tally [4];
    int unsigned idle_cycles = 0;

    task automatic report_mismatch(input string note);
        if (mismatches < REPORT_CAP)
            $display("MISMATCH @%0t: %s", $time, note);
        mismatches++;
    endtask

    // Apply one operation to the shadow table and return the result the block owes.
    function automatic outcome_t predict_outcome(input kind_t op, input word_t id,
                                                 input word_t amt);
        outcome_t       res;
        int             hit;
        int             spot;
        word_t          cur;
        logic [WORD_W:0] sum;
        hit  = -1;
        spot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && ledger_used[i] && ledger_key[i] == id)
                hit = i;
            if (spot < 0 && !ledger_used[i])
                spot = i;
        end
        cur = (hit >= 0) ? ledger_bal[hit] : '0;
        res.balance = cur;
        res.status  = ST_OK;
        if (op == KIND_CREDIT && amt != '0)
        begin
            if (hit >= 0)
            begin
                sum = {1'b0, cur} + {1'b0, amt};
                if (sum[WORD_W])
                    res.status = ST_OVERFLOW;
                else
                begin
                    ledger_bal[hit] = sum[WORD_W-1:0];
                    res.balance     = sum[WORD_W-1:0];
                end
            end
            else if (spot < 0)
                res.status = ST_FULL;
            else
            begin
                ledger_used[spot] = 1'b1;
                ledger_key[spot]  = id;
                ledger_bal[spot]  = amt;
                res.balance       = amt;
            end
        end
        else if (op == KIND_DEBIT && amt != '0)
        begin
            if (hit < 0 || amt > cur)
                res.status = ST_INSUFFICIENT;
            else
            begin
                res.balance     = cur - amt;
                ledger_bal[hit] = res.balance;
                if (res.balance == '0)
                    ledger_used[hit] = 1'b0;
            end
        end
        return res;
    endfunction

    // Often back-to-back, sometimes a short pause, rarely a long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one item, hold it until accepted, record its expected result, then
    // optionally drop valid for a gap. Valid stays high when the next item follows
    // directly, so each edge sees at most one assignment to it.
    task automatic send_item(input kind_t op, input word_t id, input word_t amt,
                             input bit known, input word_t bal, input status_t st);
        outcome_t    predicted;
        int unsigned gap;
        req_if.valid    <= 1'b1;
        req_if.kind     <= op;
        req_if.asset_id <= id;
        req_if.amount   <= amt;
        do
            @(posedge clk);
        while (!req_if.ready);
        // the predictor runs for every item so the shadow table stays in step
        predicted = predict_outcome(op, id, amt);
        if (known)
        begin
            predicted.balance = bal;
            predicted.status  = st;
        end
        pending_results.push_back(predicted);
        items_sent++;
        gap = idle_gap();
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back. Advance at
    // least one edge so the next item never drives valid in the same step.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Random operation on a key mostly drawn from a small pool, so hits, frees and a
    // full table all happen often. For 27 in 100 items the amount is the held balance
    // of the key, if any: debits then free entries and credits double the balance.
    task automatic send_random_item();
        kind_t       op;
        word_t       id;
        word_t       amt;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = KIND_CREDIT;
        else if (pick < 75)
            op = KIND_DEBIT;
        else if (pick < 95)
            op = KIND_QUERY;
        else
            op = KIND_SPARE;
        if ($urandom_range(0, 99) < 85)
            id = key_pool[$urandom_range(0, key_span - 1)];
        else
            id = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            amt = '0;
        else if (pick < 48)
            amt = word_t'($urandom_range(1, 1000));
        else if (pick < 63)
            amt = {$urandom, $urandom};
        else if (pick < 73)
            amt = ALL_ONES - word_t'($urandom_range(0, 1000));
        else
        begin
            amt = word_t'($urandom_range(1, 1000));
            for (int i = 0; i < ENTRIES; i++)
                if (ledger_used[i] && ledger_key[i] == id)
                    amt = ledger_bal[i];
        end
        send_item(op, id, amt, 1'b0, '0, ST_OK);
    endtask

    // Result side: compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with no item pending: balance=%h status=%0d",
                                          rsp_if.balance, rsp_if.status));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp_if.balance !== oldest_result.balance)
                    report_mismatch($sformatf("balance %h, expected %h",
                                              rsp_if.balance, oldest_result.balance));
                if (rsp_if.status !== oldest_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, oldest_result.status));
                results_checked++;
                status_tally[oldest_result.status]++;
            end
        end
    end

    // Watchdog: end the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved in %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result ready: bursts of acceptance broken by random stalls.
    initial
    begin
        int unsigned open_len;
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            rsp_if.ready <= 1'b1;
            if (steady)
                open_len = 50;
            else if ($urandom_range(0, 9) == 0)
                open_len = $urandom_range(5, 40);
            else
                open_len = $urandom_range(1, 4);
            repeat (open_len) @(posedge clk);
            stall = idle_gap();
            if (stall != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Sender: reset, directed walk, random phases, drain, verdict.
    initial
    begin
        req_if.valid    <= 1'b0;
        req_if.kind     <= KIND_QUERY;
        req_if.asset_id <= '0;
        req_if.amount   <= '0;
        rst_n           <= 1'b0;
        // pool: both extreme keys, the directed key and its neighbor, the rest random
        key_pool[0] = '0;
        key_pool[1] = ALL_ONES;
        key_pool[2] = KEY_A;
        key_pool[3] = KEY_A ^ 64'h1;
        for (int i = 4; i < 24; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill_rows[r])
            for (int unsigned k = 0; k < drill_rows[r].reps; k++)
                send_item(drill_rows[r].op, drill_rows[r].id + word_t'(k),
                          drill_rows[r].amt, drill_rows[r].known,
                          drill_rows[r].bal, drill_rows[r].st);
        drain_results();

        // First half on twelve keys (mostly hits and frees), second half on all
        // twenty-four (table full is frequent). One window runs with no idling.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            key_span = (n < RANDOM_ITEMS / 2) ? 12 : 24;
            steady   = (n >= 300 && n < 360);
            if (n % 150 == 149)
                drain_results();
            send_random_item();
        end
        steady = 1'b0;

        drain_results();
        // allow for a late, unexpected result
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Sent %0d items (directed walk plus random credits, debits, queries),",
                 items_sent);
        $display("%0d results checked. Refusals seen: %0d insufficient, %0d table full,",
                 results_checked, status_tally[ST_INSUFFICIENT], status_tally[ST_FULL]);
        $display("%0d overflow; %0d mismatches.", status_tally[ST_OVERFLOW], mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/kbt_pkg.sv
rtl/kbt_req_if.sv
rtl/kbt_rsp_if.sv
rtl/kbt_ram.sv
rtl/keyed_balance_table_unit.sv
verif/tb_keyed_balance_table_unit.sv
